FILE: sv/gmtzp_pkg.sv
// ---------------------------------------------------------------------------
// gmtzp_pkg
// Shared widths, register map and factor-count helpers for the grid
// least-trailing-zero path block.
// ---------------------------------------------------------------------------
package gmtzp_pkg;

    localparam int CELL_W     = 11;
    localparam int MAG_W      = 10;
    localparam int SUM_W      = 15;
    localparam int CFG_W      = 11;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int TWOS_W     = 4;
    localparam int FIVES_W    = 3;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;
    localparam int TDATA_IN_W  = 16;
    localparam int TDATA_OUT_W = 16;

    localparam logic [MAG_W-1:0] MAX_MAGNITUDE = MAG_W'(1000);

    // Register index, taken from paddr[2]
    typedef enum logic
    {
        REG_GRID_WIDTH  = 1'b0,
        REG_GRID_HEIGHT = 1'b1
    } reg_index_t;

    // Divisibility by 5^k via multiply by the odd inverse mod 2^10:
    // x is a multiple of d iff (x * inv(d)) mod 2^10 <= floor((2^10-1)/d).
    localparam logic [MAG_W-1:0] INV_5   = MAG_W'(205);
    localparam logic [MAG_W-1:0] INV_25  = MAG_W'(41);
    localparam logic [MAG_W-1:0] INV_125 = MAG_W'(213);
    localparam logic [MAG_W-1:0] INV_625 = MAG_W'(657);
    localparam logic [MAG_W-1:0] LIM_5   = MAG_W'(204);
    localparam logic [MAG_W-1:0] LIM_25  = MAG_W'(40);
    localparam logic [MAG_W-1:0] LIM_125 = MAG_W'(8);
    localparam logic [MAG_W-1:0] LIM_625 = MAG_W'(1);

    // Count trailing zero bits of a nonzero magnitude
    function automatic logic [TWOS_W-1:0] count_twos(input logic [MAG_W-1:0] mag);
        logic [TWOS_W-1:0] n;
        logic              found;
        n     = '0;
        found = 1'b0;
        for (int i = 0; i < MAG_W; i++)
        begin
            if (!found)
            begin
                if (mag[i])
                    found = 1'b1;
                else
                    n = n + TWOS_W'(1);
            end
        end
        return n;
    endfunction

    function automatic logic divisible(input logic [MAG_W-1:0] mag,
                                       input logic [MAG_W-1:0] inv,
                                       input logic [MAG_W-1:0] lim);
        logic [2*MAG_W-1:0] prod;
        prod = mag * inv;
        return (prod[MAG_W-1:0] <= lim);
    endfunction

    // Count factors of five of a nonzero magnitude at most 1000
    function automatic logic [FIVES_W-1:0] count_fives(input logic [MAG_W-1:0] mag);
        logic [FIVES_W-1:0] n;
        if (divisible(mag, INV_625, LIM_625))
            n = FIVES_W'(4);
        else if (divisible(mag, INV_125, LIM_125))
            n = FIVES_W'(3);
        else if (divisible(mag, INV_25, LIM_25))
            n = FIVES_W'(2);
        else if (divisible(mag, INV_5, LIM_5))
            n = FIVES_W'(1);
        else
            n = '0;
        return n;
    endfunction

endpackage

FILE: sv/grid_min_trailing_zero_path.sv
// ---------------------------------------------------------------------------
// grid_min_trailing_zero_path
// Least trailing zeros of a cell product along a right/down grid path.
// ---------------------------------------------------------------------------
// Usage:
//   Grid cells arrive on the s_t* stream in row-major order, one per
//   transfer. Each cell's factors of two and five are counted as it is
//   taken, then folded into running minimum path sums held in a line
//   buffer (one entry per column) plus a left-neighbor register.
//   After the last cell of a grid, one result (min of path twos and
//   path fives, capped at 1 if the grid held a zero) goes out on m_t*.
//   Grid size is set over the APB port: grid_width at 0x0, grid_height at
//   0x4; a write restarts the grid. Write only while the block is idle.
//   Throughput: one cell per cycle while no result waits at a grid end; the
//   line buffer has one read port (at accept) and one write port (from the
//   compute stage), with a bypass when both hit the same column.
//   The result is registered when the grid's last cell leaves the compute stage.
//   Reset: grid size 1x1, indices and left sums cleared; the line buffer is
//   not cleared, since the first row of each grid writes before any read.
//   When m_tready is low with a result waiting, cells keep flowing until a
//   grid's last cell reaches the compute stage; it then holds there, and
//   s_tready drops, until the waiting result is taken.
// ---------------------------------------------------------------------------
module grid_min_trailing_zero_path
(
    input  logic                              clk,
    input  logic                              rst_n,
    // APB configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [gmtzp_pkg::ADDR_W-1:0]      paddr,
    input  logic [gmtzp_pkg::DATA_W-1:0]      pwdata,
    output logic [gmtzp_pkg::DATA_W-1:0]      prdata,
    output logic                              pready,
    // Cell stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [gmtzp_pkg::TDATA_IN_W-1:0]  s_tdata,  // [10:0] cell_value
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [gmtzp_pkg::TDATA_OUT_W-1:0] m_tdata   // [14:0] min_zeros
);
    import gmtzp_pkg::*;

    logic [CFG_W-1:0]        grid_width_reg;
    logic [CFG_W-1:0]        grid_height_reg;
    logic                    cfg_write;
    logic                    accept;

    logic [COL_W-1:0]        col_reg;
    logic [ROW_W-1:0]        row_reg;
    logic [CFG_W-1:0]        eff_width;
    logic [CFG_W-1:0]        eff_height;
    logic                    last_col;
    logic                    last_row;

    logic [CELL_W-1:0]       cell_raw;
    logic [CELL_W-1:0]       neg_cell;
    logic [CELL_W-1:0]       abs_cell;
    logic [MAG_W-1:0]        mag;
    logic                    cell_zero;
    logic [TWOS_W-1:0]       twos_here;
    logic [FIVES_W-1:0]      fives_here;

    // Compute stage registers
    logic                    s1_valid_reg;
    logic [COL_W-1:0]        s1_col_reg;
    logic                    s1_first_row_reg;
    logic                    s1_first_col_reg;
    logic                    s1_last_reg;
    logic                    s1_zero_reg;
    logic [TWOS_W-1:0]       s1_twos_reg;
    logic [FIVES_W-1:0]      s1_fives_reg;
    logic [2*SUM_W-1:0]      up_reg;
    logic                    s1_fire;

    logic [SUM_W-1:0]        twos_left_reg;
    logic [SUM_W-1:0]        fives_left_reg;
    logic                    zero_seen_reg;

    logic [SUM_W-1:0]        twos_up;
    logic [SUM_W-1:0]        fives_up;
    logic [SUM_W-1:0]        twos_prev;
    logic [SUM_W-1:0]        fives_prev;
    logic [SUM_W-1:0]        twos_sum;
    logic [SUM_W-1:0]        fives_sum;
    logic                    zero_any;
    logic [SUM_W-1:0]        result_next;

    logic                    out_valid_reg;
    logic [SUM_W-1:0]        min_zeros_reg;

    logic [2*SUM_W-1:0]      line_mem [MAX_WIDTH];

    // APB: always ready, write on access phase
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (reg_index_t'(paddr[2]))
            REG_GRID_WIDTH:  prdata = DATA_W'(grid_width_reg);
            REG_GRID_HEIGHT: prdata = DATA_W'(grid_height_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= CFG_W'(1);
            grid_height_reg <= CFG_W'(1);
        end
        else if (cfg_write)
        begin
            case (reg_index_t'(paddr[2]))
                REG_GRID_WIDTH:  grid_width_reg  <= pwdata[CFG_W-1:0];
                REG_GRID_HEIGHT: grid_height_reg <= pwdata[CFG_W-1:0];
                default:         grid_width_reg  <= grid_width_reg;
            endcase
        end
    end

    // Clamp grid size to 1..max
    always_comb
    begin
        if (grid_width_reg == '0)
            eff_width = CFG_W'(1);
        else if (grid_width_reg > CFG_W'(MAX_WIDTH))
            eff_width = CFG_W'(MAX_WIDTH);
        else
            eff_width = grid_width_reg;

        if (grid_height_reg == '0)
            eff_height = CFG_W'(1);
        else if (grid_height_reg > CFG_W'(MAX_HEIGHT))
            eff_height = CFG_W'(MAX_HEIGHT);
        else
            eff_height = grid_height_reg;
    end

    assign last_col = ({1'b0, col_reg} == eff_width - CFG_W'(1));
    assign last_row = ({1'b0, row_reg} == eff_height - CFG_W'(1));

    // Count factors on the incoming cell
    assign cell_raw  = s_tdata[CELL_W-1:0];
    assign neg_cell  = -cell_raw;
    assign abs_cell  = cell_raw[CELL_W-1] ? neg_cell : cell_raw;
    assign mag       = (abs_cell > CELL_W'(MAX_MAGNITUDE)) ? MAX_MAGNITUDE
                                                           : abs_cell[MAG_W-1:0];
    assign cell_zero = (mag == '0);
    assign twos_here  = cell_zero ? TWOS_W'(1)  : count_twos(mag);
    assign fives_here = cell_zero ? FIVES_W'(1) : count_fives(mag);

    // Stall the compute stage only for a grid end with a result still waiting
    assign s1_fire  = s1_valid_reg && !(s1_last_reg && out_valid_reg && !m_tready);
    assign s_tready = !s1_valid_reg || s1_fire;
    assign accept   = s_tvalid && s_tready;

    // Advance the cell position at accept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg_write)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            if (last_col)
            begin
                col_reg <= '0;
                row_reg <= last_row ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    // Compute stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (s1_fire)
            s1_valid_reg <= 1'b0;
    end

    // Load compute stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg       <= col_reg;
            s1_first_row_reg <= (row_reg == '0);
            s1_first_col_reg <= (col_reg == '0);
            s1_last_reg      <= last_col && last_row;
            s1_zero_reg      <= cell_zero;
            s1_twos_reg      <= twos_here;
            s1_fives_reg     <= fives_here;
        end
    end

    // Line buffer: write from compute stage, read at accept with bypass
    always_ff @(posedge clk)
    begin
        if (s1_fire)
            line_mem[s1_col_reg] <= {fives_sum, twos_sum};
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (s1_fire && (s1_col_reg == col_reg))
                up_reg <= {fives_sum, twos_sum};
            else
                up_reg <= line_mem[col_reg];
        end
    end

    // Path sums: best of up and left, plus this cell
    assign twos_up  = up_reg[SUM_W-1:0];
    assign fives_up = up_reg[2*SUM_W-1:SUM_W];

    always_comb
    begin
        if (s1_first_row_reg && s1_first_col_reg)
        begin
            twos_prev  = '0;
            fives_prev = '0;
        end
        else if (s1_first_row_reg)
        begin
            twos_prev  = twos_left_reg;
            fives_prev = fives_left_reg;
        end
        else if (s1_first_col_reg)
        begin
            twos_prev  = twos_up;
            fives_prev = fives_up;
        end
        else
        begin
            twos_prev  = (twos_up < twos_left_reg) ? twos_up : twos_left_reg;
            fives_prev = (fives_up < fives_left_reg) ? fives_up : fives_left_reg;
        end
    end

    assign twos_sum  = twos_prev + SUM_W'(s1_twos_reg);
    assign fives_sum = fives_prev + SUM_W'(s1_fives_reg);
    assign zero_any  = zero_seen_reg || s1_zero_reg;

    // Final answer: smaller count, capped at one if a zero was seen
    always_comb
    begin
        result_next = (twos_sum < fives_sum) ? twos_sum : fives_sum;
        if (zero_any && (result_next > SUM_W'(1)))
            result_next = SUM_W'(1);
    end

    // Hold left sums and zero flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            twos_left_reg  <= '0;
            fives_left_reg <= '0;
            zero_seen_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            twos_left_reg  <= '0;
            fives_left_reg <= '0;
            zero_seen_reg  <= 1'b0;
        end
        else if (s1_fire)
        begin
            twos_left_reg  <= twos_sum;
            fives_left_reg <= fives_sum;
            zero_seen_reg  <= s1_last_reg ? 1'b0 : zero_any;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_fire && s1_last_reg)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_last_reg)
            min_zeros_reg <= result_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_OUT_W'(min_zeros_reg);

endmodule
